[hdl/tkct_pkg.sv]
// shared types, constants and helpers for the top-k count tracker
package tkct_pkg;

  localparam int KEY_W  = 62;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = 48;
  localparam int RANK_W = 4;
  localparam int OP_W   = 2;
  localparam int CFG_W  = 5;

  localparam int TOP_SLOTS_DEF = 16;
  localparam int KMER_LEN_DEF  = 31;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 152;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CFG_W-1:0] TOP_ENTRIES_RST = 5'd16;
  // word index taken from paddr[2]
  localparam logic REG_TOP_ENTRIES = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_OFFER   = 2'd0,
    OP_READOUT = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef struct packed {
    logic capture;
    logic offer;
    logic clear;
    logic rd_step;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic out_free;
    logic rd_last;
  } stat_t;

  // number of slots in use: zero acts as one, values past the list size saturate
  function automatic int active_count(input logic [CFG_W-1:0] v, input int slots);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > slots) n = slots;
    return n;
  endfunction

endpackage

[hdl/tkct_ctrl.sv]
// controller state machine for the top-k count tracker
module tkct_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tkct_pkg::stat_t stat_i,
  output tkct_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat_i.op)
          tkct_pkg::OP_OFFER: begin
            cmd_o.offer = 1'b1;
            state_nxt   = S_IDLE;
          end
          tkct_pkg::OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_nxt   = S_IDLE;
          end
          tkct_pkg::OP_READOUT: begin
            state_nxt = S_READ;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (stat_i.out_free) begin
          cmd_o.rd_step = 1'b1;
          if (stat_i.rd_last) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/tkct_datapath.sv]
// sorted slot list, running total, config register and output register
module tkct_datapath #(
  parameter int TOP_SLOTS = tkct_pkg::TOP_SLOTS_DEF,
  parameter int KMER_LEN  = tkct_pkg::KMER_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tkct_pkg::cmd_t              cmd_i,
  output tkct_pkg::stat_t             stat_o,
  input  logic [tkct_pkg::OP_W-1:0]   in_op_i,
  input  logic [tkct_pkg::KEY_W-1:0]  in_key_i,
  input  logic [tkct_pkg::CNT_W-1:0]  in_cnt_i,
  input  logic                        cfg_we_i,
  input  logic [tkct_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic [tkct_pkg::CFG_W-1:0]  top_entries_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tkct_pkg::RANK_W-1:0] out_rank_o,
  output logic [tkct_pkg::KEY_W-1:0]  out_key_o,
  output logic [tkct_pkg::CNT_W-1:0]  out_cnt_o,
  output logic [tkct_pkg::TOT_W-1:0]  out_total_o,
  output logic                        out_last_o
);

  localparam int KW = tkct_pkg::KEY_W;
  localparam int CW = tkct_pkg::CNT_W;
  localparam int TW = tkct_pkg::TOT_W;
  localparam int NW = $clog2(TOP_SLOTS + 1);
  localparam logic [KW-1:0] ONES = '1;
  localparam logic [KW-1:0] KEY_MASK = (2 * KMER_LEN >= KW) ? ONES : ~(ONES << (2 * KMER_LEN));

  tkct_pkg::op_t op_r;
  logic [KW-1:0] key_r;
  logic [CW-1:0] cnt_r;
  logic [KW-1:0] slot_key_r [TOP_SLOTS];
  logic [CW-1:0] slot_cnt_r [TOP_SLOTS];
  logic [TW-1:0] total_r, total_nxt;
  logic [tkct_pkg::CFG_W-1:0] top_entries_r;
  logic [NW-1:0] rd_cnt_r;
  logic [NW-1:0] n_act, n_new;
  logic [TOP_SLOTS-1:0] act, keep, cmp;
  logic [TW:0] sum;
  logic rd_last;
  logic out_valid_r;

  always_comb begin
    n_act = NW'(tkct_pkg::active_count(top_entries_r, TOP_SLOTS));
    n_new = NW'(tkct_pkg::active_count(cfg_wdata_i, TOP_SLOTS));
    rd_last = (rd_cnt_r == n_act - NW'(1));
    sum = {1'b0, total_r} + {{(TW + 1 - CW){1'b0}}, cnt_r};
    total_nxt = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  end

  // capture of the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= tkct_pkg::OP_OFFER;
    end else if (cmd_i.capture) begin
      op_r <= tkct_pkg::op_t'(in_op_i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      key_r <= in_key_i & KEY_MASK;
      cnt_r <= in_cnt_i;
    end
  end

  // one compare per slot; the list stays sorted so the compares are monotone
  genvar i;
  generate
    for (i = 0; i < TOP_SLOTS; i++) begin : g_slot
      logic [KW-1:0] key_nxt, up_key;
      logic [CW-1:0] cnt_nxt, up_cnt;
      logic          from_above;

      assign act[i]  = (i < int'(n_act));
      assign keep[i] = (i < int'(n_new));
      assign cmp[i]  = (slot_cnt_r[i] < cnt_r);

      if (i == 0) begin : g_first
        assign from_above = 1'b0;
      end else begin : g_rest
        assign from_above = cmp[i-1];
      end

      // readout rotates the active slots so slot 0 always feeds the output
      if (i < TOP_SLOTS - 1) begin : g_up
        assign up_key = (i == int'(n_act) - 1) ? slot_key_r[0] : slot_key_r[i+1];
        assign up_cnt = (i == int'(n_act) - 1) ? slot_cnt_r[0] : slot_cnt_r[i+1];
      end else begin : g_wrap
        assign up_key = slot_key_r[0];
        assign up_cnt = slot_cnt_r[0];
      end

      always_comb begin
        key_nxt = slot_key_r[i];
        cnt_nxt = slot_cnt_r[i];
        priority if (cmd_i.clear || (cfg_we_i && !keep[i])) begin
          key_nxt = '0;
          cnt_nxt = '0;
        end else if (cmd_i.offer && act[i] && cmp[i]) begin
          if (from_above) begin
            key_nxt = slot_key_r[i-1 < 0 ? 0 : i-1];
            cnt_nxt = slot_cnt_r[i-1 < 0 ? 0 : i-1];
          end else begin
            key_nxt = key_r;
            cnt_nxt = cnt_r;
          end
        end else if (cmd_i.rd_step && act[i]) begin
          key_nxt = up_key;
          cnt_nxt = up_cnt;
        end else begin
          key_nxt = slot_key_r[i];
          cnt_nxt = slot_cnt_r[i];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          slot_key_r[i] <= '0;
          slot_cnt_r[i] <= '0;
        end else begin
          slot_key_r[i] <= key_nxt;
          slot_cnt_r[i] <= cnt_nxt;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r       <= '0;
      top_entries_r <= tkct_pkg::TOP_ENTRIES_RST;
      rd_cnt_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        total_r <= '0;
      end else if (cmd_i.offer) begin
        total_r <= total_nxt;
      end
      if (cfg_we_i) top_entries_r <= cfg_wdata_i;
      if (cmd_i.capture) begin
        rd_cnt_r <= '0;
      end else if (cmd_i.rd_step) begin
        rd_cnt_r <= rd_cnt_r + NW'(1);
      end
      if (cmd_i.rd_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.rd_step) begin
      out_rank_o  <= tkct_pkg::RANK_W'(rd_cnt_r);
      out_key_o   <= slot_key_r[0];
      out_cnt_o   <= slot_cnt_r[0];
      out_total_o <= total_r;
      out_last_o  <= rd_last;
    end
  end

  assign out_valid_o     = out_valid_r;
  assign top_entries_o   = top_entries_r;
  assign stat_o.op       = op_r;
  assign stat_o.out_free = !out_valid_r || out_ready_i;
  assign stat_o.rd_last  = rd_last;

endmodule

[hdl/top_k_count_tracker.sv]
// top level of the top-k count tracker: stream ports, register port, controller and datapath
//
//  channel  | direction | handshake          | contents
//  in_      | input     | tvalid/tready      | offer, readout or clear command
//  out_     | output    | tvalid/tready      | one slot per transfer on readout
//  cfg_     | input     | apb psel/penable   | top_entries register
//
// for offer, clear and the unused code, in_tready is low while the command executes.
// readout sends the n slots in use, one slot per cycle while out_tready
// is high; a low out_tready stalls the rotation of the slot list through slot 0.
// reset (synchronous, rst_n low) empties the list and the total and sets top_entries to 16.
// a finished readout item sits in the output register while the next command is taken.
module top_k_count_tracker #(
  parameter int TOP_SLOTS = tkct_pkg::TOP_SLOTS_DEF,
  parameter int KMER_LEN  = tkct_pkg::KMER_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // kmer_code [61:0], occurrences [93:62], zero pad [95:94]
  input  logic [tkct_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation [1:0]
  input  logic [tkct_pkg::OP_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // rank [3:0], kmer_code_res [65:4], occurrences_res [97:66], total [145:98], zero pad
  output logic [tkct_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tkct_pkg::APB_AW-1:0]      cfg_paddr,
  input  logic [tkct_pkg::APB_DW-1:0]      cfg_pwdata,
  output logic [tkct_pkg::APB_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int KW = tkct_pkg::KEY_W;
  localparam int CW = tkct_pkg::CNT_W;

  tkct_pkg::cmd_t  cmd;
  tkct_pkg::stat_t stat;
  logic                        cfg_we;
  logic [tkct_pkg::CFG_W-1:0]  top_entries;
  logic [tkct_pkg::RANK_W-1:0] out_rank;
  logic [KW-1:0]               out_key;
  logic [CW-1:0]               out_cnt;
  logic [tkct_pkg::TOT_W-1:0]  out_total;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == tkct_pkg::REG_TOP_ENTRIES);
  assign cfg_prdata = (cfg_paddr[2] == tkct_pkg::REG_TOP_ENTRIES) ?
                      {{(tkct_pkg::APB_DW - tkct_pkg::CFG_W){1'b0}}, top_entries} : '0;

  assign out_tdata = {{(tkct_pkg::OUT_DATA_W - 146){1'b0}}, out_total, out_cnt, out_key, out_rank};

  tkct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tkct_datapath #(
    .TOP_SLOTS (TOP_SLOTS),
    .KMER_LEN  (KMER_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_op_i       (in_tuser),
    .in_key_i      (in_tdata[KW-1:0]),
    .in_cnt_i      (in_tdata[KW+CW-1:KW]),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_pwdata[tkct_pkg::CFG_W-1:0]),
    .top_entries_o (top_entries),
    .out_valid_o   (out_tvalid),
    .out_ready_i   (out_tready),
    .out_rank_o    (out_rank),
    .out_key_o     (out_key),
    .out_cnt_o     (out_cnt),
    .out_total_o   (out_total),
    .out_last_o    (out_tlast)
  );

endmodule

[hdl/tkct_checker.sv]
// port-level checks for the top-k count tracker, bound to the top level
module tkct_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tkct_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // one command at a time: no transfer on the cycle after a transfer
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous command in progress");

  // a readout is not finished until its last slot is loaded
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |-> !in_tready)
    else $error("input accepted in the middle of a readout");

  // next slot of the same readout follows in rank and keeps the total
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      !out_tvalid ||
      ((out_tdata[3:0] == 4'($past(out_tdata[3:0]) + 4'd1)) &&
       (out_tdata[145:98] == $past(out_tdata[145:98]))))
    else $error("readout rank or total out of sequence");

endmodule

bind top_k_count_tracker tkct_checker u_tkct_checker (.*);
